@@ rtl/wav_stream_parser_mono_mix_assert.svh @@
// Assertion macros for the WAV stream parser.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef WAV_STREAM_PARSER_MONO_MIX_ASSERT_SVH
`define WAV_STREAM_PARSER_MONO_MIX_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define WSP_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define WSP_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/wsp_pkg.sv @@
// Shared types, constants and helpers for the WAV stream parser.
// No dependencies.
package wsp_pkg;

  localparam int MAX_CHANNELS_DEF = 8;

  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;
  localparam logic [15:0] FMT_PCM   = 16'h0001;
  localparam logic [15:0] FMT_FLOAT = 16'h0003;
  localparam logic [15:0] FMT_EXT   = 16'hFFFE;

  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_NOT_RIFF   = 4'd1;
  localparam logic [3:0] ST_TRUNC      = 4'd2;
  localparam logic [3:0] ST_FMT_SHORT  = 4'd3;
  localparam logic [3:0] ST_NO_DATA    = 4'd4;
  localparam logic [3:0] ST_NO_FMT     = 4'd5;
  localparam logic [3:0] ST_BAD_FORMAT = 4'd6;
  localparam logic [3:0] ST_FLOAT_BITS = 4'd7;
  localparam logic [3:0] ST_PCM_BITS   = 4'd8;
  localparam logic [3:0] ST_TOO_MANY   = 4'd9;

  localparam logic RES_SAMPLE = 1'b0;
  localparam logic RES_STATUS = 1'b1;

  // Command from the parse controller to the datapath
  typedef struct packed {
    logic        data_en;
    logic        data_start;
    logic [7:0]  data_byte;
    logic [2:0]  sample_bytes;
    logic        float_dec;
    logic [15:0] channels;
    logic        status_en;
    logic [3:0]  status;
    logic [31:0] rate;
    logic [15:0] bits;
    logic        flt;
  } wsp_cmd_t;

  // Expected RIFF header byte at a header offset (length bytes are don't care)
  function automatic logic [7:0] hdr_byte(input logic [3:0] ofs);
    logic [7:0] r;
    r = 8'h00;
    case (ofs)
      4'd0:  r = 8'h52;
      4'd1:  r = 8'h49;
      4'd2:  r = 8'h46;
      4'd3:  r = 8'h46;
      4'd8:  r = 8'h57;
      4'd9:  r = 8'h41;
      4'd10: r = 8'h56;
      4'd11: r = 8'h45;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/wsp_if.sv @@
// Valid/ready channel interfaces for the WAV stream parser.
// Depends on nothing.
interface wsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       final_byte;
  modport source (output valid, output file_byte, output final_byte, input ready);
  modport sink (input valid, input file_byte, input final_byte, output ready);
endinterface

interface wsp_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic signed [31:0] mono_sample;
  logic [3:0]         status_code;
  logic [31:0]        rate_hz;
  logic [15:0]        channel_count;
  logic [15:0]        bits_per_sample;
  logic               float_samples;
  logic               end_of_run;
  modport source (output valid, output result_kind, output mono_sample, output status_code,
                  output rate_hz, output channel_count, output bits_per_sample,
                  output float_samples, output end_of_run, input ready);
  modport sink (input valid, input result_kind, input mono_sample, input status_code,
                input rate_hz, input channel_count, input bits_per_sample,
                input float_samples, input end_of_run, output ready);
endinterface

@@ rtl/wsp_ctrl.sv @@
// Parse controller: RIFF header, chunk walk and fmt field capture.
// Depends on wsp_pkg; drives commands to wsp_datapath.
module wsp_ctrl import wsp_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       final_i,
  output wsp_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    PH_HEADER, PH_CHUNK_HDR, PH_FMT, PH_DATA, PH_SKIP, PH_PAD, PH_DRAIN, PH_ERROR
  } phase_t;

  phase_t      ph_r, ph_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [15:0] fmt_r, fmt_nxt;
  logic [15:0] ch_r, ch_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [7:0]  sub_r, sub_nxt;
  logic        seen_r, seen_nxt;
  logic        flt_r, flt_nxt;
  logic [2:0]  sb_r, sb_nxt;
  logic [3:0]  err_r, err_nxt;

  always_comb begin
    logic [31:0] o1;
    logic [3:0]  e;
    logic [3:0]  st;
    logic        in_body;
    logic        do_body;
    logic        enter_hdr;
    phase_t      body_ph;
    ph_nxt = ph_r; cnt_nxt = cnt_r; len_nxt = len_r; tag_nxt = tag_r;
    fmt_nxt = fmt_r; ch_nxt = ch_r; rate_nxt = rate_r; bits_nxt = bits_r;
    sub_nxt = sub_r; seen_nxt = seen_r; flt_nxt = flt_r; sb_nxt = sb_r; err_nxt = err_r;
    o1 = cnt_r + 32'd1;
    e = ST_OK;
    st = ST_OK;
    in_body = 1'b0;
    do_body = 1'b0;
    enter_hdr = 1'b0;
    body_ph = PH_SKIP;
    cmd_o = '0;
    cmd_o.data_byte = byte_i;
    cmd_o.sample_bytes = sb_r;
    cmd_o.float_dec = flt_r;
    cmd_o.channels = ch_r;

    if (accept_i) begin
      unique case (ph_r)
        // Check tags, skip the RIFF length
        PH_HEADER: begin
          if ((cnt_r < 32'd4 || cnt_r >= 32'd8) && cnt_r < 32'd12 &&
              byte_i != hdr_byte(cnt_r[3:0])) begin
            err_nxt = ST_NOT_RIFF;
            ph_nxt = PH_ERROR;
          end else begin
            cnt_nxt = o1;
            if (o1 >= 32'd12) enter_hdr = 1'b1;
          end
        end
        // Gather tag and little-endian length, then open the body
        PH_CHUNK_HDR: begin
          if (cnt_r < 32'd4) tag_nxt = {tag_r[23:0], byte_i};
          else len_nxt = len_r | (32'(byte_i) << {cnt_r[1:0], 3'b000});
          cnt_nxt = o1;
          if (o1 >= 32'd8) begin
            do_body = 1'b1;
            if (tag_nxt == TAG_FMT) begin
              if (len_nxt < 32'd16) begin
                err_nxt = ST_FMT_SHORT;
                body_ph = PH_DRAIN;
              end else begin
                body_ph = PH_FMT;
              end
            end else if (tag_nxt == TAG_DATA) begin
              if (ch_r == 16'd0 || rate_r == 32'd0) e = ST_NO_FMT;
              else if (fmt_r != FMT_PCM && fmt_r != FMT_FLOAT) e = ST_BAD_FORMAT;
              else if (fmt_r == FMT_FLOAT && bits_r != 16'd32) e = ST_FLOAT_BITS;
              else if (fmt_r == FMT_PCM && bits_r != 16'd16 && bits_r != 16'd24 &&
                       bits_r != 16'd32) e = ST_PCM_BITS;
              else if (ch_r > 16'(MAX_CHANNELS)) e = ST_TOO_MANY;
              if (e != ST_OK) begin
                err_nxt = e;
                body_ph = PH_DRAIN;
              end else begin
                seen_nxt = 1'b1;
                flt_nxt = (fmt_r == FMT_FLOAT);
                sb_nxt = bits_r[5:3];
                cmd_o.data_start = 1'b1;
                body_ph = PH_DATA;
              end
            end
          end
        end
        // Chunk bodies: capture fmt fields, pass data bytes on
        PH_FMT, PH_DATA, PH_SKIP, PH_DRAIN: begin
          if (ph_r == PH_FMT) begin
            case (cnt_r)
              32'd0:  fmt_nxt = {8'h00, byte_i};
              32'd1:  fmt_nxt = {byte_i, fmt_r[7:0]};
              32'd2:  ch_nxt = {8'h00, byte_i};
              32'd3:  ch_nxt = {byte_i, ch_r[7:0]};
              32'd4:  rate_nxt = {24'h0, byte_i};
              32'd5:  rate_nxt = {16'h0, byte_i, rate_r[7:0]};
              32'd6:  rate_nxt = {8'h0, byte_i, rate_r[15:0]};
              32'd7:  rate_nxt = {byte_i, rate_r[23:0]};
              32'd14: bits_nxt = {8'h00, byte_i};
              32'd15: bits_nxt = {byte_i, bits_r[7:0]};
              32'd24: sub_nxt = byte_i;
              32'd25: if (fmt_r == FMT_EXT) fmt_nxt = {byte_i, sub_r};
              default: ;
            endcase
          end else if (ph_r == PH_DATA) begin
            cmd_o.data_en = 1'b1;
          end
          cnt_nxt = o1;
          if (o1 >= len_r) begin
            cnt_nxt = 32'd0;
            if (ph_r == PH_DRAIN) ph_nxt = PH_ERROR;
            else if (len_r[0]) ph_nxt = PH_PAD;
            else enter_hdr = 1'b1;
          end
        end
        PH_PAD: enter_hdr = 1'b1;
        PH_ERROR: ;
        default: ;
      endcase

      // Open the body, or go straight to the next chunk when it is empty
      if (do_body) begin
        cnt_nxt = 32'd0;
        if (len_nxt == 32'd0) begin
          if (body_ph == PH_DRAIN) ph_nxt = PH_ERROR;
          else enter_hdr = 1'b1;
        end else begin
          ph_nxt = body_ph;
        end
      end
      if (enter_hdr) begin
        ph_nxt = PH_CHUNK_HDR;
        cnt_nxt = 32'd0;
        len_nxt = 32'd0;
        tag_nxt = 32'd0;
      end

      // Final byte: report status and start over
      if (final_i) begin
        in_body = (ph_nxt == PH_FMT || ph_nxt == PH_DATA ||
                   ph_nxt == PH_SKIP || ph_nxt == PH_DRAIN);
        st = err_nxt;
        if (err_nxt == ST_OK) begin
          if (ph_nxt == PH_HEADER) st = ST_NOT_RIFF;
          else if (in_body) st = ST_TRUNC;
          else if (!seen_nxt) st = ST_NO_DATA;
        end else if (ph_nxt == PH_DRAIN) begin
          st = ST_TRUNC;
        end
        cmd_o.status_en = 1'b1;
        cmd_o.status = st;
        cmd_o.rate = rate_nxt;
        cmd_o.bits = bits_nxt;
        cmd_o.channels = ch_nxt;
        cmd_o.flt = (fmt_nxt == FMT_FLOAT);
        ph_nxt = PH_HEADER; cnt_nxt = '0; len_nxt = '0; tag_nxt = '0;
        fmt_nxt = '0; ch_nxt = '0; rate_nxt = '0; bits_nxt = '0; sub_nxt = '0;
        seen_nxt = 1'b0; flt_nxt = 1'b0; sb_nxt = '0; err_nxt = ST_OK;
      end
    end
  end

  // Hold parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_HEADER; cnt_r <= '0; len_r <= '0; tag_r <= '0;
      fmt_r <= '0; ch_r <= '0; rate_r <= '0; bits_r <= '0; sub_r <= '0;
      seen_r <= 1'b0; flt_r <= 1'b0; sb_r <= '0; err_r <= ST_OK;
    end else begin
      ph_r <= ph_nxt; cnt_r <= cnt_nxt; len_r <= len_nxt; tag_r <= tag_nxt;
      fmt_r <= fmt_nxt; ch_r <= ch_nxt; rate_r <= rate_nxt; bits_r <= bits_nxt;
      sub_r <= sub_nxt; seen_r <= seen_nxt; flt_r <= flt_nxt; sb_r <= sb_nxt;
      err_r <= err_nxt;
    end
  end

endmodule

@@ rtl/wsp_datapath.sv @@
// Sample assembly, Q1.31 conversion, frame sum, serial divider, result register.
// Depends on wsp_pkg, wsp_if and the assertion macro header.
`include "wav_stream_parser_mono_mix_assert.svh"
module wsp_datapath import wsp_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept_i,
  input  wsp_cmd_t   cmd_i,
  output logic       ready_o,
  wsp_out_if.source  out_chan
);

  localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
  localparam int ACC_W = 32 + $clog2(MAX_CHANNELS);
  localparam int CNT_W = $clog2(ACC_W + 1);

  logic [31:0]              sw_r;
  logic [1:0]               sbi_r;
  logic [CH_W-1:0]          ci_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     div_busy_r;
  logic [CNT_W-1:0]         dcnt_r;
  logic [CH_W:0]            rem_r;
  logic [ACC_W-1:0]         quo_r;
  logic [CH_W-1:0]          div_r;
  logic                     neg_r;
  logic                     res_hold_r;
  logic [31:0]              res_r;
  logic                     st_pend_r;
  logic [3:0]               stc_r;
  logic [31:0]              srate_r;
  logic [15:0]              sch_r;
  logic [15:0]              sbits_r;
  logic                     sflt_r;
  logic                     out_valid_r;
  logic                     okind_r;
  logic [31:0]              osmp_r;
  logic [3:0]               ost_r;
  logic [31:0]              orate_r;
  logic [15:0]              och_r;
  logic [15:0]              obits_r;
  logic                     oflt_r;

  logic [31:0]             word;
  logic                    samp_done;
  logic signed [31:0]      conv;
  logic signed [ACC_W-1:0] sum;
  logic [CH_W-1:0]         ci_inc;
  logic                    frame_done;
  logic                    start_div;
  logic [ACC_W-1:0]        mag;
  logic [CH_W:0]           rem_sh;
  logic [CH_W+1:0]         trial;
  logic [31:0]             quo_res;
  logic                    out_free;

  assign ready_o = !div_busy_r && !res_hold_r && !st_pend_r;
  assign out_free = !out_valid_r || out_chan.ready;

  // Assemble the sample and convert it to Q1.31
  always_comb begin
    logic [7:0]  ex;
    logic [31:0] fmag;
    logic [4:0]  sh;
    word = sw_r | (32'(cmd_i.data_byte) << {sbi_r, 3'b000});
    samp_done = ({1'b0, sbi_r} + 3'd1) >= cmd_i.sample_bytes;
    ex = word[30:23];
    sh = 5'(8'd126 - ex);
    fmag = {1'b1, word[22:0], 8'h00} >> 1;
    fmag = fmag >> sh;
    if (cmd_i.float_dec) begin
      if (ex == 8'hFF && word[22:0] != 23'd0) conv = 32'sd0;
      else if (ex >= 8'd127) conv = word[31] ? 32'sh80000000 : 32'sh7FFFFFFF;
      else if (ex < 8'd96) conv = 32'sd0;
      else conv = word[31] ? -$signed(fmag) : $signed(fmag);
    end else begin
      case (cmd_i.sample_bytes)
        3'd2:    conv = $signed({word[15:0], 16'h0000});
        3'd3:    conv = $signed({word[23:0], 8'h00});
        default: conv = $signed(word);
      endcase
    end
  end

  // Frame sum and divider step
  assign sum = acc_r + ACC_W'(conv);
  assign ci_inc = ci_r + CH_W'(1);
  assign frame_done = ci_inc >= cmd_i.channels[CH_W-1:0];
  assign start_div = accept_i && cmd_i.data_en && samp_done && frame_done;
  assign mag = sum[ACC_W-1] ? ACC_W'(-sum) : ACC_W'(sum);
  assign rem_sh = {rem_r[CH_W-1:0], quo_r[ACC_W-1]};
  assign trial = {1'b0, rem_sh} - {2'b00, div_r};
  assign quo_res = neg_r ? 32'(-quo_r) : quo_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbi_r <= '0;
      ci_r <= '0;
      div_busy_r <= 1'b0;
      res_hold_r <= 1'b0;
      st_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      sw_r <= '0;
      acc_r <= '0;
    end else begin
      // Clear assembly state at the start of a data chunk
      if (accept_i && cmd_i.data_start) begin
        sbi_r <= '0;
        sw_r <= '0;
        ci_r <= '0;
        acc_r <= '0;
      end else if (accept_i && cmd_i.data_en) begin
        if (samp_done) begin
          sbi_r <= '0;
          sw_r <= '0;
          if (frame_done) begin
            ci_r <= '0;
            acc_r <= '0;
          end else begin
            ci_r <= ci_inc;
            acc_r <= sum;
          end
        end else begin
          sbi_r <= sbi_r + 2'd1;
          sw_r <= word;
        end
      end

      // Launch or advance the divider
      if (start_div) begin
        div_busy_r <= 1'b1;
        dcnt_r <= CNT_W'(ACC_W);
        rem_r <= '0;
        quo_r <= mag;
        neg_r <= sum[ACC_W-1];
        div_r <= cmd_i.channels[CH_W-1:0];
      end else if (div_busy_r) begin
        if (dcnt_r == '0) begin
          div_busy_r <= 1'b0;
          res_hold_r <= 1'b1;
          res_r <= quo_res;
        end else begin
          dcnt_r <= dcnt_r - CNT_W'(1);
          if (!trial[CH_W+1]) begin
            rem_r <= trial[CH_W:0];
            quo_r <= {quo_r[ACC_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[ACC_W-2:0], 1'b0};
          end
        end
      end

      // Queue the status transaction behind any sample still in flight
      if (accept_i && cmd_i.status_en) begin
        st_pend_r <= 1'b1;
        stc_r <= cmd_i.status;
        srate_r <= cmd_i.rate;
        sch_r <= cmd_i.channels;
        sbits_r <= cmd_i.bits;
        sflt_r <= cmd_i.flt;
      end

      // Load the output register: sample first, then status
      if (out_free) begin
        if (res_hold_r) begin
          res_hold_r <= 1'b0;
          out_valid_r <= 1'b1;
          okind_r <= RES_SAMPLE;
          osmp_r <= res_r;
          ost_r <= ST_OK;
          orate_r <= '0;
          och_r <= '0;
          obits_r <= '0;
          oflt_r <= 1'b0;
        end else if (st_pend_r && !div_busy_r) begin
          st_pend_r <= 1'b0;
          out_valid_r <= 1'b1;
          okind_r <= RES_STATUS;
          osmp_r <= '0;
          ost_r <= stc_r;
          orate_r <= srate_r;
          och_r <= sch_r;
          obits_r <= sbits_r;
          oflt_r <= sflt_r;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.result_kind = okind_r;
  assign out_chan.mono_sample = $signed(osmp_r);
  assign out_chan.status_code = ost_r;
  assign out_chan.rate_hz = orate_r;
  assign out_chan.channel_count = och_r;
  assign out_chan.bits_per_sample = obits_r;
  assign out_chan.float_samples = oflt_r;
  assign out_chan.end_of_run = okind_r;

  `WSP_CHECK(a_busy_blocks_input, div_busy_r || res_hold_r, !ready_o, "input open during divide")
  `WSP_CHECK_NEXT(a_frame_starts_div, start_div, div_busy_r, "frame end did not start divider")
  `WSP_CHECK(a_hold_not_busy, res_hold_r, !div_busy_r, "divider busy with result held")
  `WSP_CHECK(a_no_accept_when_busy, accept_i, ready_o, "transaction taken while busy")

endmodule

@@ rtl/wav_stream_parser_mono_mix.sv @@
// Results: a final byte's status transaction is queued and then loaded into the output register;
// a mono sample passes through the serial divider and the result register before the output register.
// Throughput: one byte per cycle while the input is open; a byte that ends a frame starts the serial
// divider (one quotient bit per cycle), which closes input until its result is loaded into the output,
// and the final byte closes input while its status is queued; any output stall holds either longer.
// Reset: synchronous, active low; clears parse state and empties the output.
module wav_stream_parser_mono_mix import wsp_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  wsp_in_if.sink    in_chan,
  wsp_out_if.source out_chan
);

  logic     dp_ready;
  logic     accept;
  wsp_cmd_t cmd;

  assign in_chan.ready = dp_ready;
  assign accept = in_chan.valid && dp_ready;

  wsp_ctrl #(.MAX_CHANNELS(MAX_CHANNELS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (accept),
    .byte_i   (in_chan.file_byte),
    .final_i  (in_chan.final_byte),
    .cmd_o    (cmd)
  );

  wsp_datapath #(.MAX_CHANNELS(MAX_CHANNELS)) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (accept),
    .cmd_i    (cmd),
    .ready_o  (dp_ready),
    .out_chan (out_chan)
  );

endmodule
